### design/dq_pkg.sv
`default_nettype none
package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming word
    logic exec;   // perform the store access and pointer update
  } dq_cmd_t;

endpackage
`default_nettype wire

### design/dq_ram.sv
`default_nettype none
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/dq_ctrl.sv
`default_nettype none
module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dq_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_RESP
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_ACCESS;
            in_ready_r <= 1'b0;
          end
        end
        S_ACCESS: begin
          state_r     <= S_RESP;
          out_valid_r <= 1'b1;
        end
        S_RESP: begin
          if (out_ready) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_ready_r  <= 1'b1;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;
  assign cmd.load  = in_valid & in_ready_r;
  assign cmd.exec  = (state_r == S_ACCESS);

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("ready and result valid at once");

  a_word_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##1 out_valid)
    else $error("result not presented two cycles after accept");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.exec))
    else $error("load and exec in the same cycle");
`endif

endmodule
`default_nettype wire

### design/dq_dpath.sv
`default_nettype none
module dq_dpath
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dq_cmd_t                    cmd,
  input  wire logic [REQ_W-1:0]           in_req_type,
  input  wire logic signed [DATA_W-1:0]   in_value,
  output logic signed [DATA_W-1:0]        out_data,
  output logic [STAT_W-1:0]               out_status,
  output logic [$clog2(DEPTH+1)-1:0]      out_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [REQ_W-1:0]   req_r;
  logic [DATA_W-1:0]  value_r;
  logic [IDX_W-1:0]   head_r;
  logic [CNT_W-1:0]   occ_r;
  logic [STAT_W-1:0]  status_r;
  logic               data_sel_r;

  logic               full;
  logic               empty;
  logic [IDX_W-1:0]   head_dec;
  logic [IDX_W-1:0]   head_inc;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_m1;
  logic [IDX_W-1:0]   back_push;
  logic [IDX_W-1:0]   back_pop;

  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  logic [IDX_W-1:0]   head_nxt;
  logic [CNT_W-1:0]   occ_nxt;
  logic [STAT_W-1:0]  status_nxt;
  logic               data_sel_nxt;

  assign full     = (occ_r == CNT_W'(DEPTH));
  assign empty    = (occ_r == '0);
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  // back end sits at head + occ - 1, wrapped; sum stays below twice the depth
  assign sum       = SUM_W'(head_r) + SUM_W'(occ_r);
  assign sum_m1    = sum - 1'b1;
  assign back_push = (sum >= SUM_W'(DEPTH)) ? IDX_W'(sum - SUM_W'(DEPTH)) : IDX_W'(sum);
  assign back_pop  = (sum_m1 >= SUM_W'(DEPTH)) ? IDX_W'(sum_m1 - SUM_W'(DEPTH))
                                               : IDX_W'(sum_m1);

  always_comb begin
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = head_r;
    ram_raddr    = head_r;
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    status_nxt   = ST_OK;
    data_sel_nxt = 1'b0;
    unique case (req_r)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = head_dec;
          head_nxt  = head_dec;
          occ_nxt   = occ_r + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = back_push;
          occ_nxt   = occ_r + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_re       = 1'b1;
          data_sel_nxt = 1'b1;
          head_nxt     = head_inc;
          occ_nxt      = occ_r - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_re       = 1'b1;
          ram_raddr    = back_pop;
          data_sel_nxt = 1'b1;
          occ_nxt      = occ_r - 1'b1;
        end
      end
      REQ_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_re       = 1'b1;
          data_sel_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      status_r   <= status_nxt;
      data_sel_r <= data_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
  end

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec & ram_we),
    .waddr (ram_waddr),
    .wdata (value_r),
    .re    (cmd.exec & ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read data register holds until the next read, which waits for this word
  assign out_data   = data_sel_r ? ram_rdata : '0;
  assign out_status = status_r;
  assign out_count  = occ_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= IDX_W'(DEPTH - 1))
    else $error("head index out of range");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && full && (req_r == REQ_PUSH_FRONT || req_r == REQ_PUSH_BACK))
      |=> (occ_r == $past(occ_r)) && (head_r == $past(head_r)))
    else $error("push on full changed the state");
`endif

endmodule
`default_nettype wire

### design/bounded_deque.sv
// bounded_deque: double-ended queue of 32-bit words in a circular store
// result path: an accepted request word moves the controller to its access state, then the result is registered valid
// flow: one word in flight; the controller steps accept, store access and result,
//   and takes no new request word until the result has been taken
// reset: synchronous active-low rst_n empties the queue and zeroes the head;
//   store contents are not cleared
`default_nettype none
module bounded_deque
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [REQ_W-1:0]           in_req_type,
  input  wire logic signed [DATA_W-1:0]   in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [DATA_W-1:0]        out_data,
  output logic [STAT_W-1:0]               out_status,
  output logic [$clog2(DEPTH+1)-1:0]      out_count
);

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .out_data    (out_data),
    .out_status  (out_status),
    .out_count   (out_count)
  );

endmodule
`default_nettype wire

### tb/tb_bounded_deque.sv
module tb_bounded_deque;
  import dq_pkg::*;

  localparam int DQ_DEPTH   = DEPTH_DEF;
  localparam int CNT_W      = $clog2(DQ_DEPTH + 1);
  localparam int REQ_CODES  = 1 << REQ_W;
  localparam int STALL_LIMIT = 1000;
  localparam int RAND_ITEMS = 1530;
  localparam int QUIET_ITEMS = 160;
  localparam int SEG_LEN    = 40;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;
  } dq_result_t;

  class dq_scoreboard;
    logic signed [DATA_W-1:0] slots [DQ_DEPTH];
    int unsigned front;
    int unsigned held;
    dq_result_t awaited[$];
    int errors;
    int checked;
    int full_hits;
    int empty_hits;

    function new();
      front = 0;
      held = 0;
      errors = 0;
      checked = 0;
      full_hits = 0;
      empty_hits = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // advance the shadow deque by one accepted request word
    function void note_request(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] word);
      dq_result_t r;
      r.data = '0;
      r.status = ST_OK;
      case (req)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (held == DQ_DEPTH) begin
            r.status = ST_FULL;
            full_hits++;
          end else if (req == REQ_PUSH_FRONT) begin
            front = (front + DQ_DEPTH - 1) % DQ_DEPTH;
            slots[front] = word;
            held++;
          end else begin
            slots[(front + held) % DQ_DEPTH] = word;
            held++;
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
            empty_hits++;
          end else if (req == REQ_POP_BACK) begin
            r.data = slots[(front + held - 1) % DQ_DEPTH];
            held--;
          end else begin
            r.data = slots[front];
            if (req == REQ_POP_FRONT) begin
              front = (front + 1) % DQ_DEPTH;
              held--;
            end
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(held);
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] data, logic [STAT_W-1:0] status,
                               logic [CNT_W-1:0] count);
      dq_result_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: result word with nothing expected: data %0d status %0d count %0d",
                 $time, data, status, count);
        errors++;
        return;
      end
      exp = awaited[0];
      awaited.delete(0);
      checked++;
      if (data !== exp.data) begin
        $display("%0t: data mismatch: expected %0d, actual %0d", $time, exp.data, data);
        errors++;
      end
      if (status !== exp.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, exp.status, status);
        errors++;
      end
      if (count !== exp.count) begin
        $display("%0t: count mismatch: expected %0d, actual %0d", $time, exp.count, count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_data;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0] out_count;

  bit gaps_on = 1'b1;
  int idle_cycles = 0;
  int sent = 0;
  dq_scoreboard sb = new();

  bounded_deque #(.DEPTH(DQ_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .out_status(out_status),
    .out_count(out_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] word);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_value <= word;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, word);
    sent++;
  endtask

  function automatic logic [REQ_W-1:0] pick_request(int push_pct);
    int unsigned roll;
    if ($urandom_range(0, 99) < 4)
      return REQ_W'($urandom_range(REQ_PEEK_FRONT + 1, REQ_CODES - 1));
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      return $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    case ($urandom_range(0, 2))
      0: return REQ_POP_FRONT;
      1: return REQ_POP_BACK;
      default: return REQ_PEEK_FRONT;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // result side: random backpressure bursts
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data, out_status, out_count);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int push_pct;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty deque: every read flavor, then the unused codes
    send_request(REQ_POP_FRONT, 32'sh1234_5678);
    send_request(REQ_POP_BACK, -1);
    send_request(REQ_PEEK_FRONT, '0);
    for (int c = REQ_PEEK_FRONT + 1; c < REQ_CODES; c++)
      send_request(REQ_W'(c), 32'sh7fff_ffff);
    // extremes in, out from both ends, head wraps below zero
    send_request(REQ_PUSH_FRONT, 32'sh8000_0000);
    send_request(REQ_PUSH_BACK, 32'sh7fff_ffff);
    send_request(REQ_PUSH_FRONT, -1);
    send_request(REQ_PUSH_BACK, '0);
    send_request(REQ_PEEK_FRONT, '0);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_W'(REQ_PEEK_FRONT + 1), 32'sh5555_aaaa);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '0);

    // segments alternate fill-heavy, drain-heavy and balanced traffic
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % SEG_LEN == 0) begin
        case ((i / SEG_LEN) % 3)
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
        gaps_on = (i < RAND_ITEMS - QUIET_ITEMS) && ((i / SEG_LEN) % 4 != 3);
      end
      send_request(pick_request(push_pct), pick_word());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests sent, %0d results checked", sent, sb.checked);
    $display("pushes refused on a full deque: %0d, reads on an empty deque: %0d",
             sb.full_hits, sb.empty_hits);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### bounded_deque.f
design/dq_pkg.sv
design/dq_ram.sv
design/dq_ctrl.sv
design/dq_dpath.sv
design/bounded_deque.sv
tb/tb_bounded_deque.sv
